FILE: rtl/core/tqle_pkg.sv
`default_nettype none
package tqle_pkg;

    // Table geometry. A row holds the four Q values of one agent and one cell.
    localparam int AGENTS   = 8;
    localparam int CELLS    = 1024;
    localparam int AGENT_W  = 3;
    localparam int CELL_W   = 10;
    localparam int ROW_W    = AGENT_W + CELL_W;
    localparam int ROWS     = AGENTS * CELLS;
    localparam int ACTIONS  = 4;
    localparam int ACT_W    = 2;
    localparam int Q_W      = 32;
    localparam int ROW_BITS = ACTIONS * Q_W;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD_MOVE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD_MINE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REWARD_SUPERMINE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT         = 2'd3;

    localparam int DISC_W = 9;

    // Request and hit codes.
    localparam logic REQ_CHOOSE = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;
    localparam logic [1:0] HIT_NONE      = 2'd0;
    localparam logic [1:0] HIT_MINE      = 2'd1;
    localparam logic [1:0] HIT_SUPERMINE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             clear_we;
        logic [ROW_W-1:0] clear_addr;
        logic             calc_max;
        logic             calc_mul;
        logic             finish;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_update;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/core/tqle_ctrl.sv
`default_nettype none
module tqle_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire tqle_pkg::dp_status_t status,
    output tqle_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_MAX   = 6'b000100,
        S_MUL   = 6'b001000,
        S_DONE  = 6'b010000,
        S_SPARE = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [tqle_pkg::ROW_W-1:0] clr_cnt_reg, clr_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.clear_we   = 1'b0;
        cmd.clear_addr = clr_cnt_reg;
        cmd.calc_max   = 1'b0;
        cmd.calc_mul   = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                // One table row is zeroed per cycle after reset.
                cmd.clear_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == tqle_pkg::ROW_W'(tqle_pkg::ROWS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MAX;
                end
            end
            S_MAX:
            begin
                cmd.calc_max = 1'b1;
                state_next   = status.is_update ? S_MUL : S_DONE;
            end
            S_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                // The table write and the result load happen together, once the
                // output register is free.
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/tqle_datapath.sv
`default_nettype none
module tqle_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tqle_pkg::ctrl_cmd_t               cmd,
    output tqle_pkg::dp_status_t                   status,
    input  wire logic                              cfg_we,
    input  wire logic [tqle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tqle_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              req_type,
    input  wire logic [tqle_pkg::AGENT_W-1:0]      agent,
    input  wire logic [tqle_pkg::CELL_W-1:0]       cell_req,
    input  wire logic [tqle_pkg::CELL_W-1:0]       next_cell,
    input  wire logic [1:0]                        hit_kind,
    input  wire logic [7:0]                        random_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tqle_pkg::ACT_W-1:0]             action,
    output logic signed [tqle_pkg::Q_W-1:0]        written_value
);

    localparam int QW    = tqle_pkg::Q_W;
    localparam int PROD_W = QW + tqle_pkg::DISC_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int TRUNC_W = SUM_W - 8;
    localparam logic signed [TRUNC_W-1:0] SAT_MAX = TRUNC_W'(64'sd2147483647);
    localparam logic signed [TRUNC_W-1:0] SAT_MIN = TRUNC_W'(-64'sd2147483648);

    // Table memories.
    logic [tqle_pkg::ROW_BITS-1:0] q_mem [tqle_pkg::ROWS];
    logic [tqle_pkg::ACT_W-1:0]    lc_mem [tqle_pkg::ROWS];

    // Configuration registers.
    logic signed [tqle_pkg::CFG_W-1:0] reward_move_reg;
    logic signed [tqle_pkg::CFG_W-1:0] reward_mine_reg;
    logic signed [tqle_pkg::CFG_W-1:0] reward_supermine_reg;
    logic [tqle_pkg::DISC_W-1:0]       discount_reg;

    // Captured request.
    logic                         req_reg;
    logic [tqle_pkg::ROW_W-1:0]   prow_reg;
    logic [1:0]                   hit_reg;
    logic [7:0]                   rnd_reg;

    logic [tqle_pkg::ROW_BITS-1:0] rd_row_reg;
    logic [tqle_pkg::ACT_W-1:0]    lc_rd_reg;
    logic signed [QW-1:0]          max_reg;
    logic signed [PROD_W-1:0]      prod_reg;

    logic                          out_valid_reg;
    logic [tqle_pkg::ACT_W-1:0]    out_action_reg;
    logic signed [QW-1:0]          out_value_reg;

    logic [tqle_pkg::ROW_W-1:0]    rd_addr;
    logic signed [QW-1:0]          lane [tqle_pkg::ACTIONS];
    logic signed [QW-1:0]          max01, max23, row_max;
    logic [tqle_pkg::ACTIONS-1:0]  eq;
    logic [2:0]                    tie_count;
    logic [15:0]                   mul3;
    logic [7:0]                    quot3;
    logic [7:0]                    rem3;
    logic [1:0]                    rank;
    logic [1:0]                    seen;
    logic                          found;
    logic [tqle_pkg::ACT_W-1:0]    chosen;
    logic signed [tqle_pkg::CFG_W-1:0] reward;
    logic signed [SUM_W-1:0]       sum;
    logic signed [TRUNC_W-1:0]     trunc;
    logic signed [QW-1:0]          new_q;
    logic [tqle_pkg::ROW_W-1:0]    wr_addr;
    logic [tqle_pkg::ACTIONS-1:0]  lane_we;
    logic signed [QW-1:0]          wr_data;

    assign rd_addr = {agent, (req_type == tqle_pkg::REQ_UPDATE) ? next_cell : cell_req};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reward_move_reg      <= -16'sd1;
            reward_mine_reg      <= 16'sd100;
            reward_supermine_reg <= -16'sd100;
            discount_reg         <= 9'd230;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tqle_pkg::CFG_REWARD_MOVE:      reward_move_reg      <= cfg_data;
                    tqle_pkg::CFG_REWARD_MINE:      reward_mine_reg      <= cfg_data;
                    tqle_pkg::CFG_REWARD_SUPERMINE: reward_supermine_reg <= cfg_data;
                    tqle_pkg::CFG_DISCOUNT:
                        discount_reg <= cfg_data[tqle_pkg::DISC_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Memory read ports, registered.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            rd_row_reg <= q_mem[rd_addr];
            lc_rd_reg  <= lc_mem[{agent, cell_req}];
        end
    end

    // Writes: one Q lane per update, all lanes in clearing, the action on a choose.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tqle_pkg::ACTIONS; i++)
        begin
            if (lane_we[i])
            begin
                q_mem[wr_addr][i*QW +: QW] <= wr_data;
            end
        end
        if (cmd.finish && req_reg == tqle_pkg::REQ_CHOOSE)
        begin
            lc_mem[prow_reg] <= chosen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req_type;
            prow_reg <= {agent, cell_req};
            hit_reg  <= hit_kind;
            rnd_reg  <= random_value;
        end
        if (cmd.calc_max)
        begin
            max_reg <= row_max;
        end
        if (cmd.calc_mul)
        begin
            prod_reg <= $signed({1'b0, discount_reg}) * max_reg;
        end
        if (cmd.finish)
        begin
            if (req_reg == tqle_pkg::REQ_UPDATE)
            begin
                out_action_reg <= lc_rd_reg;
                out_value_reg  <= new_q;
            end
            else
            begin
                out_action_reg <= chosen;
                out_value_reg  <= '0;
            end
        end
    end

    // Row maximum as a two-level compare tree.
    always_comb
    begin
        for (int i = 0; i < tqle_pkg::ACTIONS; i++)
        begin
            lane[i] = rd_row_reg[i*QW +: QW];
        end
        max01   = (lane[1] > lane[0]) ? lane[1] : lane[0];
        max23   = (lane[3] > lane[2]) ? lane[3] : lane[2];
        row_max = (max23 > max01) ? max23 : max01;
    end

    // Tie break: rank = random modulo tie count, then the rank-th tied action.
    always_comb
    begin
        for (int i = 0; i < tqle_pkg::ACTIONS; i++)
        begin
            eq[i] = (lane[i] == max_reg);
        end
        tie_count = 3'($countones(eq));
        // Division by three through a reciprocal; exact for eight-bit values.
        mul3  = 16'(rnd_reg) * 16'd171;
        quot3 = 8'(mul3[15:9]);
        rem3  = rnd_reg - {quot3[6:0], 1'b0} - quot3;
        case (tie_count)
            3'd2:    rank = {1'b0, rnd_reg[0]};
            3'd3:    rank = rem3[1:0];
            3'd4:    rank = rnd_reg[1:0];
            default: rank = 2'd0;
        endcase
        seen   = 2'd0;
        found  = 1'b0;
        chosen = '0;
        for (int i = 0; i < tqle_pkg::ACTIONS; i++)
        begin
            if (eq[i] && !found)
            begin
                if (seen == rank)
                begin
                    found  = 1'b1;
                    chosen = tqle_pkg::ACT_W'(i);
                end
                else
                begin
                    seen = seen + 2'd1;
                end
            end
        end
    end

    // Update value: reward plus discounted maximum, truncated toward zero, saturated.
    always_comb
    begin
        case (hit_reg)
            tqle_pkg::HIT_MINE:      reward = reward_mine_reg;
            tqle_pkg::HIT_SUPERMINE: reward = reward_supermine_reg;
            default:                 reward = reward_move_reg;
        endcase
        sum   = $signed({reward, 8'd0}) + SUM_W'(prod_reg);
        trunc = sum[SUM_W-1:8] + TRUNC_W'(sum[SUM_W-1] & (|sum[7:0]));
        if (trunc > SAT_MAX)
        begin
            new_q = QW'(SAT_MAX);
        end
        else if (trunc < SAT_MIN)
        begin
            new_q = QW'(SAT_MIN);
        end
        else
        begin
            new_q = trunc[QW-1:0];
        end
    end

    always_comb
    begin
        lane_we = '0;
        wr_addr = prow_reg;
        wr_data = new_q;
        if (cmd.clear_we)
        begin
            lane_we = '1;
            wr_addr = cmd.clear_addr;
            wr_data = '0;
        end
        else if (cmd.finish && req_reg == tqle_pkg::REQ_UPDATE)
        begin
            lane_we[lc_rd_reg] = 1'b1;
        end
    end

    assign status.is_update = req_reg;
    assign status.out_busy  = out_valid_reg & ~out_ready;

    assign out_valid     = out_valid_reg;
    assign action        = out_action_reg;
    assign written_value = out_value_reg;

endmodule
`default_nettype wire

FILE: rtl/core/tabular_q_learning_engine.sv
`default_nettype none
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   req_type agent cell_req next_cell hit_kind
//                                            random_value
// result    out        out_valid / out_ready action written_value
// config    in         cfg_we                cfg_index cfg_data
//
// A request passes through these steps, the first in the accepting cycle: the table
// row read, the row maximum, the discount multiply (update only), then the
// write-back with the result load. After reset a clearing pass zeroes the Q table,
// one row per cycle, before the first request is accepted. One request is in
// flight at a time; a result that is not taken holds the write-back, and the
// request channel stays closed until then.
module tabular_q_learning_engine (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [tqle_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tqle_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [tqle_pkg::AGENT_W-1:0]      agent,
    input  wire logic [tqle_pkg::CELL_W-1:0]       cell_req,
    input  wire logic [tqle_pkg::CELL_W-1:0]       next_cell,
    input  wire logic [1:0]                        hit_kind,
    input  wire logic [7:0]                        random_value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tqle_pkg::ACT_W-1:0]             action,
    output logic signed [tqle_pkg::Q_W-1:0]        written_value
);

    tqle_pkg::ctrl_cmd_t  cmd;
    tqle_pkg::dp_status_t status;

    tqle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tqle_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .agent         (agent),
        .cell_req      (cell_req),
        .next_cell     (next_cell),
        .hit_kind      (hit_kind),
        .random_value  (random_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .action        (action),
        .written_value (written_value)
    );

endmodule
`default_nettype wire
